[sv/bid_pkg.sv]
package bid_pkg;

   typedef enum logic [2:0] {
      PH_OPCODE = 3'd0,
      PH_MODE   = 3'd1,
      PH_X      = 3'd2,
      PH_Y      = 3'd3,
      PH_Z      = 3'd4
   } phase_type;

   localparam logic [7:0] OP_HALT   = 8'h00;
   localparam logic [7:0] OP_SINGLE = 8'h01;
   localparam logic [7:0] OP_SHORT  = 8'h26;

   localparam int unsigned Y_IMM_BIT = 5;
   localparam int unsigned Z_IMM_BIT = 2;

   // register operand length in bytes: 0, 1, 2, 4
   function automatic logic [3:0] reg_len(input logic [1:0] code);
      logic [3:0] n;
      unique case (code)
         2'd0: n = 4'd0;
         2'd1: n = 4'd1;
         2'd2: n = 4'd2;
         default: n = 4'd4;
      endcase
      return n;
   endfunction

   // immediate operand length in bytes: 1, 2, 4, 8
   function automatic logic [3:0] imm_len(input logic [1:0] code);
      logic [3:0] n;
      unique case (code)
         2'd0: n = 4'd1;
         2'd1: n = 4'd2;
         2'd2: n = 4'd4;
         default: n = 4'd8;
      endcase
      return n;
   endfunction

   function automatic logic [3:0] x_len(input logic [7:0] mode);
      return reg_len(mode[7:6]);
   endfunction

   function automatic logic [3:0] y_len(input logic [7:0] mode);
      return mode[Y_IMM_BIT] ? imm_len(mode[4:3]) : reg_len(mode[4:3]);
   endfunction

   function automatic logic [3:0] z_len(input logic [7:0] mode);
      return mode[Z_IMM_BIT] ? imm_len(mode[1:0]) : reg_len(mode[1:0]);
   endfunction

endpackage

[sv/bytecode_instruction_decoder_top.sv]
// Bytecode instruction decoder. Takes one code byte per cycle on req_ and
// returns one decoded instruction on rsp_ in the cycle after its last byte
// is accepted. An instruction is 1 to 22 bytes long. The only stall is the
// result register: req_ready drops while a finished instruction waits and
// rsp_ready is low. Opcodes 0x00, 0x01 and 0x26 are single-byte; any other
// opcode is followed by a mode byte and then the X, Y and Z operand bytes,
// little-endian.
module bytecode_instruction_decoder_top
   import bid_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_code_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_opcode,
   output logic        rsp_has_operands,
   output logic [7:0]  rsp_mode_byte,
   output logic [31:0] rsp_dest_register,
   output logic [63:0] rsp_y_value,
   output logic        rsp_y_immediate,
   output logic [63:0] rsp_z_value,
   output logic        rsp_z_immediate,
   output logic [4:0]  rsp_instr_length
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  opcode_ff, opcode_in;
   logic [7:0]  mode_ff, mode_in;
   logic [3:0]  left_ff, left_in;
   logic [31:0] x_ff, x_in;
   logic [63:0] y_ff, y_in;
   logic [63:0] z_ff, z_in;
   logic [4:0]  count_ff, count_in;

   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_opcode_ff;
   logic        out_ops_ff;
   logic [7:0]  out_mode_ff;
   logic [31:0] out_x_ff;
   logic [63:0] out_y_ff;
   logic [63:0] out_z_ff;
   logic [4:0]  out_len_ff;

   logic        accept;
   logic        done;
   logic        with_ops;
   logic [7:0]  b;

   assign req_ready = !out_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign b         = req_code_byte;

   always_comb begin
      logic [3:0] cur_len;
      logic [2:0] pos;
      logic [3:0] xl, yl, zl;
      phase_in  = phase_ff;
      opcode_in = opcode_ff;
      mode_in   = mode_ff;
      left_in   = left_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      z_in      = z_ff;
      count_in  = count_ff;
      done      = 1'b0;
      with_ops  = 1'b1;
      cur_len   = 4'd0;
      pos       = 3'd0;
      xl        = x_len(mode_ff);
      yl        = y_len(mode_ff);
      zl        = z_len(mode_ff);
      unique case (phase_ff)
         PH_MODE: begin
            mode_in  = b;
            count_in = count_ff + 5'd1;
            xl       = x_len(b);
            yl       = y_len(b);
            zl       = z_len(b);
            if (xl != 4'd0) begin
               phase_in = PH_X;
               left_in  = xl;
            end else if (yl != 4'd0) begin
               phase_in = PH_Y;
               left_in  = yl;
            end else if (zl != 4'd0) begin
               phase_in = PH_Z;
               left_in  = zl;
            end else begin
               done = 1'b1;
            end
         end
         PH_X, PH_Y, PH_Z: begin
            cur_len  = (phase_ff == PH_X) ? xl : ((phase_ff == PH_Y) ? yl : zl);
            pos      = 3'(cur_len - left_ff);
            count_in = count_ff + 5'd1;
            left_in  = left_ff - 4'd1;
            if (phase_ff == PH_X) begin
               if (pos[2] == 1'b0) begin
                  x_in[8*pos[1:0] +: 8] = x_ff[8*pos[1:0] +: 8] | b;
               end
            end else if (phase_ff == PH_Y) begin
               y_in[8*pos +: 8] = y_ff[8*pos +: 8] | b;
            end else begin
               z_in[8*pos +: 8] = z_ff[8*pos +: 8] | b;
            end
            if (left_in == 4'd0) begin
               if (phase_ff == PH_X && yl != 4'd0) begin
                  phase_in = PH_Y;
                  left_in  = yl;
               end else if (phase_ff != PH_Z && zl != 4'd0) begin
                  phase_in = PH_Z;
                  left_in  = zl;
               end else begin
                  done = 1'b1;
               end
            end
         end
         default: begin
            opcode_in = b;
            mode_in   = 8'd0;
            x_in      = 32'd0;
            y_in      = 64'd0;
            z_in      = 64'd0;
            left_in   = 4'd0;
            count_in  = 5'd1;
            if (b == OP_HALT || b == OP_SINGLE || b == OP_SHORT) begin
               done     = 1'b1;
               with_ops = 1'b0;
            end else begin
               phase_in = PH_MODE;
            end
         end
      endcase
      if (done) begin
         phase_in = PH_OPCODE;
         left_in  = 4'd0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      if (accept && done) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_OPCODE;
         opcode_ff    <= 8'd0;
         mode_ff      <= 8'd0;
         left_ff      <= 4'd0;
         x_ff         <= 32'd0;
         y_ff         <= 64'd0;
         z_ff         <= 64'd0;
         count_ff     <= 5'd0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (accept) begin
            phase_ff  <= phase_in;
            opcode_ff <= opcode_in;
            mode_ff   <= mode_in;
            left_ff   <= left_in;
            x_ff      <= x_in;
            y_ff      <= y_in;
            z_ff      <= z_in;
            count_ff  <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && done) begin
         out_opcode_ff <= opcode_in;
         out_ops_ff    <= with_ops;
         out_mode_ff   <= with_ops ? mode_in : 8'd0;
         out_x_ff      <= with_ops ? x_in : 32'd0;
         out_y_ff      <= with_ops ? y_in : 64'd0;
         out_z_ff      <= with_ops ? z_in : 64'd0;
         out_len_ff    <= count_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_opcode        = out_opcode_ff;
   assign rsp_has_operands  = out_ops_ff;
   assign rsp_mode_byte     = out_mode_ff;
   assign rsp_dest_register = out_x_ff;
   assign rsp_y_value       = out_y_ff;
   assign rsp_y_immediate   = out_mode_ff[Y_IMM_BIT];
   assign rsp_z_value       = out_z_ff;
   assign rsp_z_immediate   = out_mode_ff[Z_IMM_BIT];
   assign rsp_instr_length  = out_len_ff;

`ifndef SYNTHESIS
   a_single_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_operands |-> rsp_instr_length == 5'd1 && rsp_mode_byte == 8'd0)
      else $error("single-byte word with wrong length or mode");

   a_ops_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_operands |-> rsp_instr_length >= 5'd2)
      else $error("operand word shorter than two bytes");

   a_left_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_X || phase_ff == PH_Y || phase_ff == PH_Z) |-> left_ff != 4'd0)
      else $error("operand phase with no bytes left");

   a_idle_left: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_OPCODE || phase_ff == PH_MODE) |-> left_ff == 4'd0)
      else $error("byte count left over outside operand phase");
`endif

endmodule

[tb/tb_bytecode_instruction_decoder_top.sv]
module tb_bytecode_instruction_decoder_top;
   import bid_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [7:0]  opcode;
      logic        has_operands;
      logic [7:0]  mode_byte;
      logic [31:0] dest_register;
      logic [63:0] y_value;
      logic        y_immediate;
      logic [63:0] z_value;
      logic        z_immediate;
      logic [4:0]  instr_length;
   } decoded_instr_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_code_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_opcode;
   logic        rsp_has_operands;
   logic [7:0]  rsp_mode_byte;
   logic [31:0] rsp_dest_register;
   logic [63:0] rsp_y_value;
   logic        rsp_y_immediate;
   logic [63:0] rsp_z_value;
   logic        rsp_z_immediate;
   logic [4:0]  rsp_instr_length;

   decoded_instr_type pending_instrs[$];
   int          error_count = 0;
   int          bytes_sent = 0;
   bit          idle_on = 1'b1;
   bit          hold_start = 1'b0;
   bit          hold_on = 1'b0;

   // decode state mirrored by the testbench
   phase_type   dec_phase = PH_OPCODE;
   logic [7:0]  cur_op = 8'h00;
   logic [7:0]  cur_mode = 8'h00;
   logic [3:0]  bytes_rem = 4'd0;
   logic [31:0] x_acc = '0;
   logic [63:0] y_acc = '0;
   logic [63:0] z_acc = '0;
   logic [4:0]  byte_count = 5'd0;

   bytecode_instruction_decoder_top uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_code_byte(req_code_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_opcode(rsp_opcode),
      .rsp_has_operands(rsp_has_operands),
      .rsp_mode_byte(rsp_mode_byte),
      .rsp_dest_register(rsp_dest_register),
      .rsp_y_value(rsp_y_value),
      .rsp_y_immediate(rsp_y_immediate),
      .rsp_z_value(rsp_z_value),
      .rsp_z_immediate(rsp_z_immediate),
      .rsp_instr_length(rsp_instr_length)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [3:0] operand_len(input logic [7:0] mode, input phase_type which);
      logic [1:0] code;
      logic       imm;
      code = (which == PH_X) ? mode[7:6] : (which == PH_Y) ? mode[4:3] : mode[1:0];
      imm  = (which == PH_Y) ? mode[Y_IMM_BIT] : (which == PH_Z) ? mode[Z_IMM_BIT] : 1'b0;
      case (code)
         2'd0: return imm ? 4'd1 : 4'd0;
         2'd1: return imm ? 4'd2 : 4'd1;
         2'd2: return imm ? 4'd4 : 4'd2;
         default: return imm ? 4'd8 : 4'd4;
      endcase
   endfunction

   function void emit_instruction(input bit with_ops);
      decoded_instr_type d;
      d.opcode        = cur_op;
      d.has_operands  = with_ops;
      d.mode_byte     = with_ops ? cur_mode : 8'h00;
      d.dest_register = with_ops ? x_acc : 32'h0;
      d.y_value       = with_ops ? y_acc : 64'h0;
      d.y_immediate   = with_ops ? cur_mode[Y_IMM_BIT] : 1'b0;
      d.z_value       = with_ops ? z_acc : 64'h0;
      d.z_immediate   = with_ops ? cur_mode[Z_IMM_BIT] : 1'b0;
      d.instr_length  = byte_count;
      pending_instrs.push_back(d);
      dec_phase = PH_OPCODE;
      bytes_rem = 4'd0;
   endfunction

   // skip empty operands; finish when none is left
   function void next_operand(input int from);
      logic [3:0] n;
      for (int p = from + 1; p <= int'(PH_Z); p++) begin
         n = operand_len(cur_mode, phase_type'(p));
         if (n != 4'd0) begin
            dec_phase = phase_type'(p);
            bytes_rem = n;
            return;
         end
      end
      emit_instruction(1'b1);
   endfunction

   function void decode_byte(input logic [7:0] b);
      int shift;
      case (dec_phase)
         PH_MODE: begin
            cur_mode = b;
            byte_count = byte_count + 5'd1;
            next_operand(PH_MODE);
         end
         PH_X, PH_Y, PH_Z: begin
            shift = 8 * ((operand_len(cur_mode, dec_phase) - bytes_rem) & 4'd7);
            if (dec_phase == PH_X)
               x_acc = x_acc | (32'(b) << shift);
            else if (dec_phase == PH_Y)
               y_acc = y_acc | (64'(b) << shift);
            else
               z_acc = z_acc | (64'(b) << shift);
            byte_count = byte_count + 5'd1;
            bytes_rem = bytes_rem - 4'd1;
            if (bytes_rem == 4'd0)
               next_operand(dec_phase);
         end
         default: begin
            cur_op = b;
            cur_mode = 8'h00;
            x_acc = '0;
            y_acc = '0;
            z_acc = '0;
            bytes_rem = 4'd0;
            byte_count = 5'd1;
            if (b == OP_HALT || b == OP_SINGLE || b == OP_SHORT)
               emit_instruction(1'b0);
            else
               dec_phase = PH_MODE;
         end
      endcase
   endfunction

   function void check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] got_v);
      if (exp_v !== got_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, got_v);
         error_count++;
      end
   endfunction

   task check_instruction();
      decoded_instr_type e;
      if (pending_instrs.size() == 0) begin
         $error("unexpected word: opcode %0h", rsp_opcode);
         error_count++;
         return;
      end
      e = pending_instrs.pop_front();
      check_field("opcode", e.opcode, rsp_opcode);
      check_field("has_operands", e.has_operands, rsp_has_operands);
      check_field("mode_byte", e.mode_byte, rsp_mode_byte);
      check_field("dest_register", e.dest_register, rsp_dest_register);
      check_field("y_value", e.y_value, rsp_y_value);
      check_field("y_immediate", e.y_immediate, rsp_y_immediate);
      check_field("z_value", e.z_value, rsp_z_value);
      check_field("z_immediate", e.z_immediate, rsp_z_immediate);
      check_field("instr_length", e.instr_length, rsp_instr_length);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         check_instruction();
      if (hold_on) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !(idle_on && $urandom_range(99) < 36);
      end
   end

   // long receiver hold-off
   initial begin
      wait (hold_start);
      hold_on = 1'b1;
      for (int i = 0; i < 150; i++) @(posedge clock);
      hold_on = 1'b0;
   end

   task send_byte(input logic [7:0] b);
      while (idle_on && $urandom_range(99) < 36) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_code_byte <= b;
      do
         @(posedge clock);
      while (!req_ready);
      decode_byte(b);
      bytes_sent++;
   endtask

   task send_instruction(input logic [7:0] op, input logic [7:0] mode, input bit ones);
      int n;
      n = operand_len(mode, PH_X) + operand_len(mode, PH_Y) + operand_len(mode, PH_Z);
      send_byte(op);
      if (op == OP_HALT || op == OP_SINGLE || op == OP_SHORT)
         return;
      send_byte(mode);
      for (int i = 0; i < n; i++)
         send_byte(ones ? 8'hFF : 8'($urandom));
   endtask

   task send_random_instruction();
      int r;
      logic [7:0] mode;
      r = $urandom_range(99);
      mode = ($urandom_range(9) == 0) ? 8'h00 : ($urandom_range(9) == 0) ? 8'hFF
                                                                       : 8'($urandom);
      if (r < 15) begin
         case ($urandom_range(2))
            0: send_byte(OP_HALT);
            1: send_byte(OP_SINGLE);
            default: send_byte(OP_SHORT);
         endcase
      end else if (r < 90) begin
         send_instruction(8'($urandom), mode, 1'b0);
      end else begin
         repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
      end
   endtask

   task wait_drained();
      req_valid <= 1'b0;
      while (pending_instrs.size() != 0) @(posedge clock);
   endtask

   task test_single_byte_opcodes();
      send_byte(OP_HALT);
      send_byte(OP_SINGLE);
      send_byte(OP_SHORT);
   endtask

   task test_empty_operands();
      send_instruction(8'hFF, 8'h00, 1'b0);
   endtask

   task test_longest_instruction();
      send_instruction(8'h02, 8'hFF, 1'b1);
   endtask

   task test_burst_no_idle();
      idle_on = 1'b0;
      repeat (40) send_random_instruction();
      idle_on = 1'b1;
   endtask

   task test_output_backpressure();
      hold_start = 1'b1;
      repeat (30) send_byte(OP_SINGLE);
      repeat (10) send_random_instruction();
   endtask

   task test_drain_pause();
      repeat (5) send_random_instruction();
      wait_drained();
      repeat (5) send_random_instruction();
   endtask

   task test_random_stream(input int target);
      int stop_at;
      stop_at = bytes_sent + target;
      while (bytes_sent < stop_at) send_random_instruction();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_single_byte_opcodes();
      test_empty_operands();
      test_longest_instruction();
      test_burst_no_idle();
      test_output_backpressure();
      test_drain_pause();
      test_random_stream(1050);
      wait_drained();
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("bytecode_instruction_decoder_top regression: pass");
      else
         $display("bytecode_instruction_decoder_top regression: fail");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("bytecode_instruction_decoder_top regression: fail");
      $finish;
   end

endmodule

[filelist.f]
sv/bid_pkg.sv
sv/bytecode_instruction_decoder_top.sv
tb/tb_bytecode_instruction_decoder_top.sv
